// ----- src/tif_pkg.sv -----
// shared types, constants and coefficient helpers for the three-axis iir filter
package tif_pkg;

    // fixed geometry
    localparam int NumAxis   = 3;
    localparam int CoefIntW  = 6;
    localparam int MulChunkW = 24;
    localparam int ChunkIdxW = 2;
    localparam int NumCoef   = 19;
    localparam int CoefIdW   = 5;
    localparam int TapIdxW   = 4;
    localparam int SlotW     = 3;

    typedef logic signed [31:0] t_rate;
    typedef logic [2:0]         t_mode;

    // filter mode codes
    localparam t_mode MODE_LP_A      = 3'd1;
    localparam t_mode MODE_LP_10HZ   = 3'd3;
    localparam t_mode MODE_BANDPASS  = 3'd4;

    // operand source of a tap
    localparam logic [1:0] SRC_SMP = 2'd0;
    localparam logic [1:0] SRC_Y   = 2'd1;
    localparam logic [1:0] SRC_X   = 2'd2;

    // coefficient table layout
    localparam logic [CoefIdW-1:0] CID_BP_B0  = 5'd0;
    localparam logic [CoefIdW-1:0] CID_BP_FB0 = 5'd1;
    localparam logic [CoefIdW-1:0] CID_BP_FF1 = 5'd9;
    localparam logic [CoefIdW-1:0] CID_LP_A   = 5'd13;
    localparam logic [CoefIdW-1:0] CID_LP_B   = 5'd16;

    // bandpass tap list
    localparam logic [TapIdxW-1:0] TAP_BP_FB_LO = 4'd1;
    localparam logic [TapIdxW-1:0] TAP_BP_FB_HI = 4'd8;
    localparam logic [TapIdxW-1:0] TAP_BP_FF_LO = 4'd9;
    localparam logic [TapIdxW-1:0] TAP_BP_LAST  = 4'd12;
    localparam logic [TapIdxW-1:0] TAP_LP_Y     = 4'd0;
    localparam logic [TapIdxW-1:0] TAP_LP_X     = 4'd1;

    typedef struct packed {
        logic [1:0]         src;
        logic [SlotW-1:0]   slot;
        logic [CoefIdW-1:0] coef_id;
        logic               last;
    } t_tap;

    typedef struct packed {
        logic                 valid;
        logic [CoefIdW-1:0]   coef_id;
        logic [ChunkIdxW-1:0] chunk;
    } t_mac_op;

    // coefficient magnitudes in units of 1e-15
    localparam logic [55:0] CoefMag [NumCoef] = '{
        56'd3362815128981,
        56'd6398795086770444, 56'd18056234987997165, 56'd29398420877873452,
        56'd30245469352207913, 56'd20147981514639788, 56'd8487696789614214,
        56'd2067013962137406, 56'd222811572920135,
        56'd13451260515926, 56'd20176890773888, 56'd13451260515926, 56'd3362815128981,
        56'd509540000000000, 56'd854080685463467, 56'd726542528005361,
        56'd245230000000000, 56'd72959657268267, 56'd136728735997319
    };
    localparam logic [NumCoef-1:0] CoefNeg = 19'b000_0000_1011_0101_0100;

    localparam logic [127:0] DecScale = 128'd1000000000000000;
    localparam logic [127:0] DecHalf  = 128'd500000000000000;

    // decimal coefficient to fixed point, round half away from zero
    function automatic logic signed [63:0] quant_coef(input logic [55:0] mag,
                                                      input logic neg, input int frac);
        logic [127:0] num;
        logic [127:0] q;
        num = (128'(mag) << frac) + DecHalf;
        q   = num / DecScale;
        return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    // tap list of the active mode
    function automatic t_tap tap_info(input logic bp, input logic [1:0] lp_sel,
                                      input logic [TapIdxW-1:0] idx);
        t_tap t;
        t.src     = SRC_SMP;
        t.slot    = '0;
        t.coef_id = CID_BP_B0;
        t.last    = 1'b0;
        if (bp) begin
            if (idx inside {[TAP_BP_FB_LO:TAP_BP_FB_HI]}) begin
                t.src     = SRC_Y;
                t.slot    = SlotW'(idx - TAP_BP_FB_LO);
                t.coef_id = CID_BP_FB0 + CoefIdW'(idx - TAP_BP_FB_LO);
            end else if (idx inside {[TAP_BP_FF_LO:TAP_BP_LAST]}) begin
                t.src     = SRC_X;
                t.slot    = {SlotW'(idx - TAP_BP_FF_LO)} << 1 | SlotW'(1);
                t.coef_id = CID_BP_FF1 + CoefIdW'(idx - TAP_BP_FF_LO);
                t.last    = (idx == TAP_BP_LAST);
            end else begin
                t.last    = (idx > TAP_BP_LAST);
            end
        end else begin
            case (idx)
                TAP_LP_Y: begin
                    t.src     = SRC_Y;
                    t.coef_id = CID_LP_A + CoefIdW'(lp_sel);
                end
                TAP_LP_X: begin
                    t.src     = SRC_X;
                    t.coef_id = CID_LP_B + CoefIdW'(lp_sel);
                end
                default: begin
                    t.src     = SRC_SMP;
                    t.coef_id = CID_LP_B + CoefIdW'(lp_sel);
                    t.last    = 1'b1;
                end
            endcase
        end
        return t;
    endfunction

endpackage

// ----- src/tif_in_if.sv -----
// input channel: one three-axis rate sample per beat
interface tif_in_if;
    import tif_pkg::*;

    logic  valid;
    logic  ready;
    t_rate rate_x;
    t_rate rate_y;
    t_rate rate_z;

    modport source (output valid, output rate_x, output rate_y, output rate_z, input ready);
    modport sink   (input valid, input rate_x, input rate_y, input rate_z, output ready);
endinterface

// ----- src/tif_out_if.sv -----
// output channel: one three-axis filtered sample per beat
interface tif_out_if;
    import tif_pkg::*;

    logic  valid;
    logic  ready;
    t_rate filtered_x;
    t_rate filtered_y;
    t_rate filtered_z;

    modport source (output valid, output filtered_x, output filtered_y, output filtered_z,
                    input ready);
    modport sink   (input valid, input filtered_x, input filtered_y, input filtered_z,
                    output ready);
endinterface

// ----- src/tif_hist_mem.sv -----
// history memory: one write port, one registered read port, per-entry valid bits
module tif_hist_mem #(
    parameter int DEPTH  = 24,
    parameter int DATA_W = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [$clog2(DEPTH)-1:0]      i_waddr,
    input  logic signed [DATA_W-1:0]      i_wdata,
    input  logic [$clog2(DEPTH)-1:0]      i_raddr,
    output logic signed [DATA_W-1:0]      o_rdata
);
    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]         r_vld;
    logic signed [DATA_W-1:0] r_rdata;
    logic                     r_rvld;

    // storage array, no reset
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    // entries read as zero until first written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rvld <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;
endmodule

// ----- src/tif_mac.sv -----
// chunked multiply-accumulate with rounding and saturation to the sample format
module tif_mac #(
    parameter int SAMPLE_WIDTH   = 32,
    parameter int COEF_FRAC_BITS = 40
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_clr,
    input  tif_pkg::t_mac_op               i_op,
    input  logic signed [SAMPLE_WIDTH-1:0] i_operand,
    output logic signed [SAMPLE_WIDTH-1:0] o_y
);
    import tif_pkg::*;

    localparam int CoefW    = COEF_FRAC_BITS + CoefIntW;
    localparam int NumChunk = (CoefW + MulChunkW - 1) / MulChunkW;
    localparam int CoefExtW = NumChunk * MulChunkW;
    localparam int ProdW    = MulChunkW + 1 + SAMPLE_WIDTH;
    localparam int AccW     = CoefW + SAMPLE_WIDTH + 4;

    localparam logic signed [AccW-1:0] Half   = AccW'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [AccW-1:0] MaxPos = (AccW'(1) << (SAMPLE_WIDTH - 1)) - AccW'(1);
    localparam logic signed [AccW-1:0] MinNeg = -(AccW'(1) << (SAMPLE_WIDTH - 1));

    typedef logic signed [CoefW-1:0] t_coef_tab [NumCoef];

    function automatic t_coef_tab build_coef_tab();
        t_coef_tab tab;
        for (int i = 0; i < NumCoef; i++) begin
            tab[i] = CoefW'(quant_coef(CoefMag[i], CoefNeg[i], COEF_FRAC_BITS));
        end
        return tab;
    endfunction

    localparam t_coef_tab CoefTab = build_coef_tab();

    logic signed [CoefExtW-1:0]  coef_ext;
    logic [MulChunkW-1:0]        slice;
    logic signed [MulChunkW:0]   c_chunk;
    logic signed [ProdW-1:0]     prod;
    logic signed [AccW-1:0]      prod_ext;
    logic signed [AccW-1:0]      rnd;
    logic signed [AccW-1:0]      shr;

    logic signed [ProdW-1:0]     r_prod;
    logic [ChunkIdxW-1:0]        r_pchunk;
    logic                        r_pvld;
    logic signed [AccW-1:0]      r_acc;

    // coefficient slice: low slices unsigned, top slice signed
    always_comb begin
        coef_ext = CoefExtW'(CoefTab[i_op.coef_id]);
        slice    = coef_ext[i_op.chunk * MulChunkW +: MulChunkW];
        if (i_op.chunk == ChunkIdxW'(NumChunk - 1)) begin
            c_chunk = {slice[MulChunkW-1], slice};
        end else begin
            c_chunk = {1'b0, slice};
        end
        prod = c_chunk * i_operand;
    end

    // product stage
    always_ff @(posedge i_clk) begin
        r_prod   <= prod;
        r_pchunk <= i_op.chunk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else begin
            r_pvld <= i_op.valid;
        end
    end

    // accumulate the aligned partial product
    assign prod_ext = AccW'(r_prod) <<< (MulChunkW * r_pchunk);

    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_acc <= '0;
        end else if (r_pvld) begin
            r_acc <= r_acc + prod_ext;
        end
    end

    // round to nearest and saturate
    always_comb begin
        rnd = r_acc + Half;
        shr = rnd >>> COEF_FRAC_BITS;
        if (shr > MaxPos) begin
            o_y = SAMPLE_WIDTH'(MaxPos);
        end else if (shr < MinNeg) begin
            o_y = SAMPLE_WIDTH'(MinNeg);
        end else begin
            o_y = SAMPLE_WIDTH'(shr);
        end
    end
endmodule

// ----- src/three_axis_iir_filter_core.sv -----
// top level: sequencer, history memories and mac of the three-axis iir filter
//
// Takes one three-axis gyro rate beat on i_rate and returns one filtered beat on
// o_filt. Both channels use valid/ready; a beat moves when both are high.
// The user must see that filter mode is written through i_cfg_we/i_cfg_wdata
// only while the block is idle; the block itself does not enforce it. Input and
// output histories sit in two memories (three axes of HISTORY_DEPTH entries
// each) addressed as rings, so the bandpass shift is a pointer step. One shared
// mac walks the taps of each axis; each tap is split into NumChunk coefficient
// chunks (2 at the default coefficient width) for the chunked multiplier.
// A bypass beat goes straight to the output register without the mac.
// Input ready is high only when no beat is in work. A finished beat waits in
// an output register, so a new beat is taken while the receiver stalls; a
// second finished beat holds until that register frees.
// Reset clears the mode to bypass and marks all history entries as zero.
module three_axis_iir_filter_core #(
    parameter int HISTORY_DEPTH  = 8,
    parameter int SAMPLE_WIDTH   = 32,
    parameter int COEF_FRAC_BITS = 40
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  tif_pkg::t_mode i_cfg_wdata,
    tif_in_if.sink         i_rate,
    tif_out_if.source      o_filt
);
    import tif_pkg::*;

    localparam int CoefW    = COEF_FRAC_BITS + CoefIntW;
    localparam int NumChunk = (CoefW + MulChunkW - 1) / MulChunkW;
    localparam int NumEntry = NumAxis * HISTORY_DEPTH;
    localparam int AddrW    = $clog2(NumEntry);
    localparam int HeadW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [1:0] LastAx = 2'(NumAxis - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RUN   = 3'd1;
    localparam logic [2:0] S_WAIT1 = 3'd2;
    localparam logic [2:0] S_WAIT2 = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]                r_state;
    t_mode                     r_mode;
    logic                      r_bp;
    logic [1:0]                r_lp_sel;
    logic [1:0]                r_ax;
    logic [TapIdxW-1:0]        r_tap;
    logic [ChunkIdxW-1:0]      r_chunk;
    logic [HeadW-1:0]          r_head;
    t_mac_op                   r_op1;
    logic [1:0]                r_src1;
    logic                      r_kill1;
    logic                      r_ov;
    logic signed [SAMPLE_WIDTH-1:0] r_smp [NumAxis];
    logic signed [SAMPLE_WIDTH-1:0] r_res [NumAxis];
    t_rate                     r_out_x;
    t_rate                     r_out_y;
    t_rate                     r_out_z;

    logic                      is_lp;
    logic                      is_bp;
    logic                      in_acc;
    logic                      out_free;
    t_tap                      tap;
    logic                      kill0;
    logic [4:0]                diff;
    logic [4:0]                phys;
    logic [AddrW-1:0]          base;
    logic [AddrW-1:0]          raddr;
    logic [AddrW-1:0]          waddr;
    logic [HeadW-1:0]          head_next;
    logic [HeadW-1:0]          wslot;
    t_mac_op                   op0;
    logic                      mac_clr;
    logic                      mem_we;
    logic signed [SAMPLE_WIDTH-1:0] ext_smp [NumAxis];
    logic signed [SAMPLE_WIDTH-1:0] y_rdata;
    logic signed [SAMPLE_WIDTH-1:0] x_rdata;
    logic signed [SAMPLE_WIDTH-1:0] operand;
    logic signed [SAMPLE_WIDTH-1:0] mac_y;

    // handshakes and mode decode
    assign i_rate.ready = (r_state == S_IDLE);
    assign in_acc       = i_rate.valid && i_rate.ready;
    assign out_free     = !r_ov || o_filt.ready;
    assign is_lp        = r_mode inside {[MODE_LP_A:MODE_LP_10HZ]};
    assign is_bp        = (r_mode == MODE_BANDPASS);

    // input samples taken from the low SAMPLE_WIDTH bits
    assign ext_smp[0] = SAMPLE_WIDTH'($unsigned(i_rate.rate_x));
    assign ext_smp[1] = SAMPLE_WIDTH'($unsigned(i_rate.rate_y));
    assign ext_smp[2] = SAMPLE_WIDTH'($unsigned(i_rate.rate_z));

    // tap decode and ring addressing
    always_comb begin
        tap   = tap_info(r_bp, r_lp_sel, r_tap);
        kill0 = (tap.src != SRC_SMP) && ({1'b0, tap.slot} >= 4'(HISTORY_DEPTH));
        diff  = 5'(r_head) - 5'(tap.slot);
        phys  = diff[4] ? diff + 5'(HISTORY_DEPTH) : diff;
        case (r_ax)
            2'd0:    base = '0;
            2'd1:    base = AddrW'(HISTORY_DEPTH);
            default: base = AddrW'(2 * HISTORY_DEPTH);
        endcase
        raddr     = base + (kill0 ? '0 : AddrW'(phys));
        head_next = (r_head == HeadW'(HISTORY_DEPTH - 1)) ? '0 : r_head + 1'b1;
        wslot     = r_bp ? head_next : r_head;
        waddr     = base + AddrW'(wslot);
        op0.valid   = (r_state == S_RUN);
        op0.coef_id = tap.coef_id;
        op0.chunk   = r_chunk;
        mac_clr     = (r_state == S_IDLE) || (r_state == S_FIN);
        mem_we      = (r_state == S_FIN);
    end

    // operand select, aligned with the registered memory read
    always_comb begin
        case (r_src1)
            SRC_Y:   operand = y_rdata;
            SRC_X:   operand = x_rdata;
            default: operand = r_smp[r_ax];
        endcase
        if (r_kill1) begin
            operand = '0;
        end
    end

    tif_hist_mem #(
        .DEPTH  (NumEntry),
        .DATA_W (SAMPLE_WIDTH)
    ) u_y_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (waddr),
        .i_wdata (mac_y),
        .i_raddr (raddr),
        .o_rdata (y_rdata)
    );

    tif_hist_mem #(
        .DEPTH  (NumEntry),
        .DATA_W (SAMPLE_WIDTH)
    ) u_x_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (waddr),
        .i_wdata (r_smp[r_ax]),
        .i_raddr (raddr),
        .o_rdata (x_rdata)
    );

    tif_mac #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (mac_clr),
        .i_op      (r_op1),
        .i_operand (operand),
        .o_y       (mac_y)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= '0;
            r_bp     <= 1'b0;
            r_lp_sel <= '0;
            r_ax     <= '0;
            r_tap    <= '0;
            r_chunk  <= '0;
            r_head   <= '0;
            r_op1    <= '0;
            r_src1   <= SRC_SMP;
            r_kill1  <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            r_op1   <= op0;
            r_src1  <= tap.src;
            r_kill1 <= kill0;
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_bp     <= is_bp;
                        r_lp_sel <= 2'(r_mode - MODE_LP_A);
                        r_ax     <= '0;
                        r_tap    <= '0;
                        r_chunk  <= '0;
                        r_state  <= (is_bp || is_lp) ? S_RUN : S_DONE;
                    end
                end
                S_RUN: begin
                    if (r_chunk == ChunkIdxW'(NumChunk - 1)) begin
                        r_chunk <= '0;
                        if (tap.last) begin
                            r_tap   <= '0;
                            r_state <= S_WAIT1;
                        end else begin
                            r_tap <= r_tap + 1'b1;
                        end
                    end else begin
                        r_chunk <= r_chunk + 1'b1;
                    end
                end
                S_WAIT1: r_state <= S_WAIT2;
                S_WAIT2: r_state <= S_FIN;
                S_FIN: begin
                    if (r_ax == LastAx) begin
                        if (r_bp) begin
                            r_head <= head_next;
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_ax    <= r_ax + 1'b1;
                        r_state <= S_RUN;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // output beat register
            if (r_state == S_DONE && out_free) begin
                r_ov <= 1'b1;
            end else if (o_filt.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // sample, result and output payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_smp <= ext_smp;
            r_res <= ext_smp;
        end
        if (r_state == S_FIN) begin
            r_res[r_ax] <= mac_y;
        end
        if (r_state == S_DONE && out_free) begin
            r_out_x <= 32'(r_res[0]);
            r_out_y <= 32'(r_res[1]);
            r_out_z <= 32'(r_res[2]);
        end
    end

    assign o_filt.valid      = r_ov;
    assign o_filt.filtered_x = r_out_x;
    assign o_filt.filtered_y = r_out_y;
    assign o_filt.filtered_z = r_out_z;

    // mac pipeline is empty whenever a new beat can be taken
    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_op1.valid)
        else $error("mac op in flight while idle");

    // ring pointer steps only at the end of a bandpass beat
    a_head_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head != $past(r_head)) |-> $past(r_state == S_FIN && r_bp && r_ax == LastAx))
        else $error("history ring moved outside bandpass write-back");

    // write-back only after the accumulator has drained
    a_fin_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> $past(r_state == S_WAIT2))
        else $error("write-back before mac drained");

    // output beat is loaded only from the done state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_filt.valid) |-> $past(r_state == S_DONE))
        else $error("output beat raised outside done state");
endmodule
